/* rtl/core/udpq_pkg.sv */
// Shared types and codes for the UDP port demultiplexer.
package udpq_pkg;
  typedef enum logic [2:0] {
    REQ_ALLOC  = 3'd0,
    REQ_FREE   = 3'd1,
    REQ_BIND   = 3'd2,
    REQ_HDR    = 3'd3,
    REQ_BYTE   = 3'd4,
    REQ_RXOPEN = 3'd5,
    REQ_READ   = 3'd6
  } req_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_IN_USE  = 3'd2,
    ST_NO_SLOT = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_DROPPED = 3'd5
  } status_t;

  localparam logic [15:0] EPH_RESET = 16'd40000;

  typedef struct packed {
    logic        req;
    logic [15:0] port;
    logic [5:0]  skip;
  } scan_cmd_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] idx;
  } scan_res_t;
endpackage

/* rtl/core/udpq_ram.sv */
// Generic single-port RAM with registered read.
module udpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* rtl/core/udpq_scan.sv */
// Port compare unit: lowest bound socket with a given port.
module udpq_scan #(
  parameter int SOCKETS = 8
) (
  input  logic [SOCKETS-1:0]       live,
  input  logic [15:0]              ports [SOCKETS],
  input  udpq_pkg::scan_cmd_t      cmd,
  output udpq_pkg::scan_res_t      res
);
  import udpq_pkg::*;

  always_comb begin
    res = '0;
    for (int i = SOCKETS - 1; i >= 0; i--) begin
      if (cmd.req && live[i] && ports[i] == cmd.port && 6'(i) != cmd.skip) begin
        res.hit = 1'b1;
        res.idx = 6'(i);
      end
    end
  end
endmodule

/* rtl/core/udp_port_demux_queues_unit.sv */
// Top level of the UDP port demultiplexer with per-socket receive queues.
// The result is presented from S_WAIT after the word passes S_EXEC and S_OUT; receive open
// of a queued packet (header table read) and read byte (payload RAM read) also pass S_HDR or S_RDB.
// One word in flight; the next is accepted the cycle after the result is taken.
// Reset clears slot table, rings and sessions; ephemeral counter and base return to 40000.
// Payload and header RAMs are not cleared.
module udp_port_demux_queues_unit #(
  parameter int SOCKETS       = 8,
  parameter int QUEUE_DEPTH   = 8,
  parameter int PAYLOAD_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [2:0]  in_sock_index,
  input  logic [31:0] in_local_addr,
  input  logic [15:0] in_port,
  input  logic [31:0] in_src_addr,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_payload_len,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_buf_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [2:0]  out_sock_index_res,
  output logic [15:0] out_bound_port,
  output logic [31:0] out_pkt_src_addr,
  output logic [15:0] out_pkt_src_port,
  output logic [9:0]  out_byte_count,
  output logic [7:0]  out_read_data,
  output logic        out_last
);
  import udpq_pkg::*;

  localparam int SW = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = SW + QW;
  localparam int ENTRIES = SOCKETS * QUEUE_DEPTH;
  localparam int LW = $clog2(PAYLOAD_BYTES + 1);
  localparam int OW = $clog2(PAYLOAD_BYTES);
  localparam int AW = $clog2(ENTRIES * PAYLOAD_BYTES);
  localparam int HW = 32 + 16 + LW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_HDR   = 6'b000100,
    S_RDB   = 6'b001000,
    S_OUT   = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  state_t state_r;
  logic [15:0] base_r, eph_r;
  logic [SOCKETS-1:0] used_r, bound_r;
  logic [31:0] saddr_r [SOCKETS];
  logic [15:0] sport_r [SOCKETS];
  logic [QW-1:0] head_r [SOCKETS];
  logic [QW-1:0] tail_r [SOCKETS];
  logic [CW-1:0] cnt_r [SOCKETS];
  logic fill_act_r, read_act_r;
  logic [EW-1:0] fill_e_r;
  logic [LW-1:0] fill_off_r, fill_len_r;
  logic [SW-1:0] read_slot_r;
  logic [LW-1:0] read_off_r, read_tot_r;

  logic [2:0]  req_r, sidx_r;
  logic [31:0] laddr_r, src_a_r;
  logic [15:0] port_r, src_p_r, plen_r, blen_r;
  logic [7:0]  dbyte_r;

  logic [2:0]  o_st_r, o_si_r;
  logic [15:0] o_bp_r, o_sp_r;
  logic [31:0] o_sa_r;
  logic [9:0]  o_bc_r;
  logic [7:0]  o_rd_r;
  logic        o_last_r;

  // shared compare unit
  scan_cmd_t scmd;
  scan_res_t sres;
  logic [SOCKETS-1:0] live;
  assign live = used_r & bound_r;

  udpq_scan #(.SOCKETS(SOCKETS)) u_scan (
    .live(live), .ports(sport_r), .cmd(scmd), .res(sres)
  );

  // header table
  logic          h_we;
  logic [EW-1:0] h_addr;
  logic [HW-1:0] h_wdata, h_rdata;
  udpq_ram #(.WIDTH(HW), .DEPTH(1 << EW)) u_hdr (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
  );

  logic          p_we;
  logic [AW-1:0] p_addr;
  logic [7:0]    p_rdata;
  udpq_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_pay (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(dbyte_r), .rdata(p_rdata)
  );

  logic sok;
  logic [SW-1:0] si;
  assign si = sidx_r[SW-1:0];
  assign sok = 32'(sidx_r) < SOCKETS;

  // lowest free slot
  logic alloc_hit;
  logic [SW-1:0] alloc_s;
  always_comb begin
    alloc_hit = 1'b0;
    alloc_s = '0;
    for (int i = SOCKETS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        alloc_hit = 1'b1;
        alloc_s = SW'(i);
      end
    end
  end

  // ephemeral port handling
  logic [15:0] eph_inc, eph_nxt_v, eph_sw;
  assign eph_inc = eph_r + 16'd1;
  assign eph_nxt_v = (eph_inc < base_r) ? base_r : eph_inc;
  assign eph_sw = {eph_r[7:0], eph_r[15:8]};

  logic bind_eph;
  logic [15:0] bind_port;
  always_comb begin
    bind_eph = (req_r == REQ_RXOPEN) || (port_r == 16'd0);
    bind_port = bind_eph ? eph_sw : port_r;
  end

  logic [EW-1:0] hdr_e, open_e;
  logic [LW-1:0] plen_cap;
  logic [SW-1:0] hit_s;
  assign hit_s = sres.idx[SW-1:0];
  assign hdr_e = EW'({hit_s, tail_r[hit_s]});
  assign open_e = EW'({si, head_r[si]});
  assign plen_cap = (plen_r > 16'(PAYLOAD_BYTES)) ? LW'(PAYLOAD_BYTES) : plen_r[LW-1:0];

  logic [LW-1:0] hlen;
  logic [LW-1:0] n_open;
  assign hlen = h_rdata[LW-1:0];
  assign n_open = ({6'd0, blen_r} < 22'(hlen)) ? blen_r[LW-1:0] : hlen;

  always_comb begin
    scmd.req  = (state_r == S_EXEC) &&
                (req_r == REQ_BIND || req_r == REQ_HDR ||
                 (req_r == REQ_RXOPEN && !bound_r[si]));
    scmd.port = (req_r == REQ_HDR) ? port_r : bind_port;
    scmd.skip = (req_r == REQ_HDR) ? 6'h3f : 6'(si);
    h_we   = 1'b0;
    h_addr = open_e;
    h_wdata = {src_a_r, src_p_r, plen_cap};
    p_we   = 1'b0;
    p_addr = AW'({fill_e_r, fill_off_r[OW-1:0]});
    if (state_r == S_EXEC && req_r == REQ_HDR && sres.hit &&
        32'(cnt_r[hit_s]) < QUEUE_DEPTH) begin
      h_we = 1'b1;
      h_addr = hdr_e;
    end
    if (state_r == S_EXEC && req_r == REQ_BYTE && fill_act_r) p_we = 1'b1;
    if (state_r == S_EXEC && req_r == REQ_READ)
      p_addr = AW'({read_slot_r, head_r[read_slot_r], read_off_r[OW-1:0]});
  end

  logic [LW-1:0] fill_off_inc, read_off_inc;
  assign fill_off_inc = fill_off_r + LW'(1);
  assign read_off_inc = read_off_r + LW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      base_r <= EPH_RESET;
      eph_r <= EPH_RESET;
      used_r <= '0;
      bound_r <= '0;
      fill_act_r <= 1'b0;
      read_act_r <= 1'b0;
      for (int i = 0; i < SOCKETS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i] <= '0;
        sport_r[i] <= '0;
        saddr_r[i] <= '0;
      end
    end else begin
      if (cfg_we) base_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r <= in_req_type; sidx_r <= in_sock_index;
            laddr_r <= in_local_addr; port_r <= in_port;
            src_a_r <= in_src_addr; src_p_r <= in_src_port;
            plen_r <= in_payload_len; dbyte_r <= in_data_byte;
            blen_r <= in_buf_len;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          o_st_r <= ST_INVALID; o_si_r <= '0; o_bp_r <= '0; o_sa_r <= '0;
          o_sp_r <= '0; o_bc_r <= '0; o_rd_r <= '0; o_last_r <= 1'b0;
          state_r <= S_OUT;
          unique case (req_r)
            REQ_ALLOC: begin
              o_st_r <= ST_NO_SLOT;
              if (alloc_hit) begin
                o_st_r <= ST_OK;
                o_si_r <= 3'(alloc_s);
                used_r[alloc_s] <= 1'b1;
                bound_r[alloc_s] <= 1'b0;
                saddr_r[alloc_s] <= '0; sport_r[alloc_s] <= '0;
                head_r[alloc_s] <= '0; tail_r[alloc_s] <= '0; cnt_r[alloc_s] <= '0;
                if (fill_act_r && fill_e_r[EW-1:QW] == alloc_s) fill_act_r <= 1'b0;
                if (read_act_r && read_slot_r == alloc_s) read_act_r <= 1'b0;
              end
            end
            REQ_FREE: begin
              if (sok) begin
                o_st_r <= ST_OK;
                used_r[si] <= 1'b0; bound_r[si] <= 1'b0;
                saddr_r[si] <= '0; sport_r[si] <= '0;
                head_r[si] <= '0; tail_r[si] <= '0; cnt_r[si] <= '0;
                if (fill_act_r && fill_e_r[EW-1:QW] == si) fill_act_r <= 1'b0;
                if (read_act_r && read_slot_r == si) read_act_r <= 1'b0;
              end
            end
            REQ_BIND: begin
              if (sok && used_r[si]) begin
                if (port_r == 16'd0) eph_r <= eph_nxt_v;
                if (sres.hit) o_st_r <= ST_IN_USE;
                else begin
                  o_st_r <= ST_OK; o_bp_r <= bind_port;
                  saddr_r[si] <= laddr_r; sport_r[si] <= bind_port;
                  bound_r[si] <= 1'b1;
                end
              end
            end
            REQ_HDR: begin
              fill_act_r <= 1'b0;
              o_st_r <= ST_DROPPED;
              if (sres.hit) begin
                o_si_r <= 3'(hit_s);
                if (32'(cnt_r[hit_s]) < QUEUE_DEPTH) begin
                  o_st_r <= ST_OK;
                  tail_r[hit_s] <= (32'(tail_r[hit_s]) == QUEUE_DEPTH - 1) ? '0 :
                                   tail_r[hit_s] + QW'(1);
                  cnt_r[hit_s] <= cnt_r[hit_s] + CW'(1);
                  fill_act_r <= plen_cap != '0;
                  fill_e_r <= hdr_e;
                  fill_off_r <= '0;
                  fill_len_r <= plen_cap;
                end
              end
            end
            REQ_BYTE: begin
              if (fill_act_r) begin
                o_st_r <= ST_OK;
                fill_off_r <= fill_off_inc;
                if (fill_off_inc >= fill_len_r) fill_act_r <= 1'b0;
              end
            end
            REQ_RXOPEN: begin
              if (sok && used_r[si]) begin
                if (!bound_r[si]) begin
                  eph_r <= eph_nxt_v;
                  if (!sres.hit) begin
                    saddr_r[si] <= '0; sport_r[si] <= bind_port;
                    bound_r[si] <= 1'b1;
                    o_bp_r <= bind_port;
                  end
                end else o_bp_r <= sport_r[si];
                if (cnt_r[si] == '0) o_st_r <= ST_EMPTY;
                else begin
                  o_st_r <= ST_OK;
                  state_r <= S_HDR;
                end
              end
            end
            REQ_READ: begin
              if (read_act_r) state_r <= S_RDB;
            end
            default: ;
          endcase
        end
        S_HDR: begin
          o_sa_r <= h_rdata[HW-1:HW-32];
          o_sp_r <= h_rdata[LW+15:LW];
          o_bc_r <= 10'(n_open);
          read_act_r <= 1'b0;
          if (n_open == '0) begin
            o_last_r <= 1'b1;
            head_r[si] <= (32'(head_r[si]) == QUEUE_DEPTH - 1) ? '0 : head_r[si] + QW'(1);
            cnt_r[si] <= cnt_r[si] - CW'(1);
          end else begin
            read_act_r <= 1'b1;
            read_slot_r <= si;
            read_off_r <= '0;
            read_tot_r <= n_open;
          end
          state_r <= S_OUT;
        end
        S_RDB: begin
          o_st_r <= ST_OK;
          o_rd_r <= p_rdata;
          read_off_r <= read_off_inc;
          if (read_off_inc >= read_tot_r) begin
            o_last_r <= 1'b1;
            read_act_r <= 1'b0;
            if (cnt_r[read_slot_r] != '0) begin
              head_r[read_slot_r] <= (32'(head_r[read_slot_r]) == QUEUE_DEPTH - 1) ? '0 :
                                     head_r[read_slot_r] + QW'(1);
              cnt_r[read_slot_r] <= cnt_r[read_slot_r] - CW'(1);
            end
          end
          state_r <= S_OUT;
        end
        S_OUT: state_r <= S_WAIT;
        S_WAIT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_WAIT);
  assign out_status = o_st_r;
  assign out_sock_index_res = o_si_r;
  assign out_bound_port = o_bp_r;
  assign out_pkt_src_addr = o_sa_r;
  assign out_pkt_src_port = o_sp_r;
  assign out_byte_count = o_bc_r;
  assign out_read_data = o_rd_r;
  assign out_last = o_last_r;
endmodule

/* rtl/core/udpq_checker.sv */
// Port-level checker for the UDP demultiplexer, bound to the top level.
module udpq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic       out_last
);
  import udpq_pkg::*;

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accepting while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_DROPPED) else $error("bad status");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_status == ST_OK) else $error("last on error");
endmodule

bind udp_port_demux_queues_unit udpq_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_last(out_last)
);
